@@ design/sstg_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Square and sine tone generator: shared package
// Widths, register reset values, register indexes, the structs that pass
// between the front, the back and the divider, and the sine ROM builder.
// ============================================================================
package sstg_pkg;

   // Table and request sizing.
   localparam int SINE_TABLE_DEPTH       = 1024;
   localparam int SINE_IDX_W             = $clog2(SINE_TABLE_DEPTH);
   localparam int MAX_FRAMES_PER_REQUEST = 64;

   // Field widths.
   localparam int FRAME_COUNT_W = 7;
   localparam int SAMPLE_W      = 16;
   localparam int CURSOR_W      = 24;
   localparam int WAVELEN_W     = 16;
   localparam int AMP_W         = 15;
   localparam int CSR_DATA_W    = 24;
   localparam int CSR_INDEX_W   = 2;

   // Iterative divider sizing.
   localparam int DIV_DVD_W  = CURSOR_W + 1;
   localparam int DIV_DSR_W  = CURSOR_W;
   localparam int DIV_STEP_W = 5;

   // Register reset values.
   localparam logic [WAVELEN_W-1:0] SAMPLES_PER_CYCLE_RESET = 16'd187;
   localparam logic [AMP_W-1:0]     AMPLITUDE_RESET         = 15'd3000;
   localparam logic                 WAVE_SELECT_RESET       = 1'b1;
   localparam logic [CURSOR_W-1:0]  CURSOR_WRAP_RESET       = 24'd192000;

   // Waveform codes.
   localparam logic WAVE_SQUARE = 1'b0;
   localparam logic WAVE_SINE   = 1'b1;

   // Full scale of the Q1.15 sine table.
   localparam logic [SAMPLE_W-1:0] SINE_FULL_SCALE = 16'h7FFF;

   // Fixed point constants for the table builder.
   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLES_PER_CYCLE = 2'd0,
      CSR_AMPLITUDE         = 2'd1,
      CSR_WAVE_SELECT       = 2'd2,
      CSR_CURSOR_WRAP       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WAVELEN_W-1:0] samples_per_cycle;
      logic [AMP_W-1:0]     amplitude;
      logic                 wave_select;
      logic [CURSOR_W-1:0]  cursor_wrap;
   } cfg_type;

   // Command from the front queue to the back.
   typedef struct packed {
      logic                     valid;
      logic [FRAME_COUNT_W-1:0] count;
   } cmd_type;

   // Divider launch and result.
   typedef struct packed {
      logic                  start;
      logic [DIV_DVD_W-1:0]  dividend;
      logic [DIV_DSR_W-1:0]  divisor;
      logic [DIV_DSR_W-1:0]  rem_init;
      logic [DIV_STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_DVD_W-1:0] quotient;
      logic [DIV_DSR_W-1:0] remainder;
   } div_rsp_type;

   typedef logic signed [SAMPLE_W-1:0] sine_rom_type [SINE_TABLE_DEPTH];

   // Builds the Q1.15 sine table at elaboration: the angle in Q30 radians is
   // folded into the first quadrant, a Taylor series up to the thirteenth
   // power is summed with truncated terms, and the result is rounded.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  mag;
      logic         neg;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         x   = (64'd2 * PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
         neg = 1'b0;
         if (x >= PI_Q30) begin
            neg = 1'b1;
            x   = x - PI_Q30;
         end
         if (x > (PI_Q30 >> 1)) begin
            x = PI_Q30 - x;
         end
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         term = ((term * x2) >> 30) / 64'd6;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd42;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd110;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd156;
         sum  = sum + term;
         if (sum > ONE_Q30) begin
            sum = ONE_Q30;
         end
         mag    = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
         rom[k] = neg ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
      end
      return rom;
   endfunction

endpackage

@@ design/sstg_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tone generator front
// Holds the configuration registers, accepts requests, saturates the frame
// count, drops empty requests and queues the rest for the back.
// ============================================================================
module sstg_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [sstg_pkg::FRAME_COUNT_W-1:0]   req_frame_count,
   input  logic                                 csr_wr_en,
   input  logic [sstg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sstg_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output sstg_pkg::cfg_type                    cfg,
   output sstg_pkg::cmd_type                    cmd,
   input  logic                                 cmd_pop
);

   localparam int QUEUE_DEPTH = 2;

   sstg_pkg::cfg_type cfg_ff;
   sstg_pkg::cfg_type cfg_in;

   logic [sstg_pkg::FRAME_COUNT_W-1:0] slot_ff [QUEUE_DEPTH];
   logic                               wr_ptr_ff;
   logic                               wr_ptr_in;
   logic                               rd_ptr_ff;
   logic                               rd_ptr_in;
   logic [1:0]                         fill_ff;
   logic [1:0]                         fill_in;
   logic [sstg_pkg::FRAME_COUNT_W-1:0] clamped_count;
   logic                               queue_write;

   // Register writes decoded by index; other codes leave the registers alone.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (sstg_pkg::csr_index_type'(csr_index))
            sstg_pkg::CSR_SAMPLES_PER_CYCLE: begin
               cfg_in.samples_per_cycle = csr_wdata[sstg_pkg::WAVELEN_W-1:0];
            end
            sstg_pkg::CSR_AMPLITUDE: begin
               cfg_in.amplitude = csr_wdata[sstg_pkg::AMP_W-1:0];
            end
            sstg_pkg::CSR_WAVE_SELECT: begin
               cfg_in.wave_select = csr_wdata[0];
            end
            sstg_pkg::CSR_CURSOR_WRAP: begin
               cfg_in.cursor_wrap = csr_wdata[sstg_pkg::CURSOR_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.samples_per_cycle <= sstg_pkg::SAMPLES_PER_CYCLE_RESET;
         cfg_ff.amplitude         <= sstg_pkg::AMPLITUDE_RESET;
         cfg_ff.wave_select       <= sstg_pkg::WAVE_SELECT_RESET;
         cfg_ff.cursor_wrap       <= sstg_pkg::CURSOR_WRAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // Saturate oversized requests; an empty request is taken but not queued.
   assign clamped_count =
      (req_frame_count > sstg_pkg::FRAME_COUNT_W'(sstg_pkg::MAX_FRAMES_PER_REQUEST)) ?
      sstg_pkg::FRAME_COUNT_W'(sstg_pkg::MAX_FRAMES_PER_REQUEST) : req_frame_count;

   assign full        = (fill_ff == 2'(QUEUE_DEPTH));
   assign queue_write = push && !full && (clamped_count != '0);

   // Two-entry command queue between the front and the back.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (queue_write) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (cmd_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (queue_write && !cmd_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!queue_write && cmd_pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_write) begin
         slot_ff[wr_ptr_ff] <= clamped_count;
      end
   end

   assign cmd.valid = (fill_ff != 2'd0);
   assign cmd.count = slot_ff[rd_ptr_ff];

endmodule

@@ design/sstg_divider.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tone generator divider
// Restoring shift-subtract divider, one quotient bit per cycle. The dividend
// shifts out at the top while quotient bits shift in at the bottom; the
// remainder may be preloaded to continue a division.
// ============================================================================
module sstg_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  sstg_pkg::div_req_type req,
   output sstg_pkg::div_rsp_type rsp
);

   logic                              busy_ff;
   logic                              busy_in;
   logic                              done_ff;
   logic                              done_in;
   logic [sstg_pkg::DIV_STEP_W-1:0]   step_ff;
   logic [sstg_pkg::DIV_STEP_W-1:0]   step_in;
   logic [sstg_pkg::DIV_DVD_W-1:0]    dvd_ff;
   logic [sstg_pkg::DIV_DVD_W-1:0]    dvd_in;
   logic [sstg_pkg::DIV_DSR_W-1:0]    rem_ff;
   logic [sstg_pkg::DIV_DSR_W-1:0]    rem_in;
   logic [sstg_pkg::DIV_DSR_W-1:0]    dsr_ff;
   logic [sstg_pkg::DIV_DSR_W-1:0]    dsr_in;
   logic [sstg_pkg::DIV_DSR_W:0]      partial;
   logic [sstg_pkg::DIV_DSR_W:0]      diff;
   logic                              fits;

   // One trial subtraction per cycle.
   assign partial = {rem_ff, dvd_ff[sstg_pkg::DIV_DVD_W-1]};
   assign diff    = partial - {1'b0, dsr_ff};
   assign fits    = (partial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = req.steps;
         dvd_in  = req.dividend;
         rem_in  = req.rem_init;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[sstg_pkg::DIV_DVD_W-2:0], fits};
         rem_in  = fits ? diff[sstg_pkg::DIV_DSR_W-1:0] : partial[sstg_pkg::DIV_DSR_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == sstg_pkg::DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = dvd_ff;
   assign rsp.remainder = rem_ff;

endmodule

@@ design/sstg_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tone generator back
// Takes queued requests and produces one frame at a time: phase and table
// index through the shared divider, sine ROM read, amplitude scaling, and
// the cursor advance. Finished frames wait in the output register.
// ============================================================================
module sstg_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  sstg_pkg::cfg_type                       cfg,
   input  sstg_pkg::cmd_type                       cmd,
   output logic                                    cmd_pop,
   output sstg_pkg::div_req_type                   div_req,
   input  sstg_pkg::div_rsp_type                   div_rsp,
   output logic                                    empty,
   input  logic                                    pop,
   output logic signed [sstg_pkg::SAMPLE_W-1:0]    rsp_left_sample,
   output logic signed [sstg_pkg::SAMPLE_W-1:0]    rsp_right_sample,
   output logic [sstg_pkg::CURSOR_W-1:0]           rsp_frame_index,
   output logic                                    rsp_last
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_START    = 8'b0000_0010,
      ST_DIV_MAIN = 8'b0000_0100,
      ST_DIV_IDX  = 8'b0000_1000,
      ST_MUL      = 8'b0001_0000,
      ST_SCALE    = 8'b0010_0000,
      ST_EMIT     = 8'b0100_0000,
      ST_WRAP     = 8'b1000_0000
   } state_type;

   localparam sstg_pkg::sine_rom_type SINE_ROM = sstg_pkg::build_sine_rom();

   state_type                                state_ff;
   state_type                                state_in;
   logic [sstg_pkg::FRAME_COUNT_W-1:0]       frames_left_ff;
   logic [sstg_pkg::FRAME_COUNT_W-1:0]       frames_left_in;
   logic [sstg_pkg::CURSOR_W-1:0]            cursor_ff;
   logic [sstg_pkg::CURSOR_W-1:0]            cursor_in;
   logic signed [sstg_pkg::SAMPLE_W-1:0]     rom_data_ff;
   logic [2*sstg_pkg::AMP_W-1:0]             product_ff;
   logic [2*sstg_pkg::AMP_W-1:0]             product_in;
   logic                                     negative_ff;
   logic                                     negative_in;
   logic signed [sstg_pkg::SAMPLE_W-1:0]     sample_ff;
   logic signed [sstg_pkg::SAMPLE_W-1:0]     sample_in;
   logic                                     out_valid_ff;
   logic                                     out_valid_in;
   logic signed [sstg_pkg::SAMPLE_W-1:0]     out_sample_ff;
   logic [sstg_pkg::CURSOR_W-1:0]            out_index_ff;
   logic                                     out_last_ff;
   logic                                     out_load;

   logic [sstg_pkg::WAVELEN_W-1:0]           wavelen;
   logic [sstg_pkg::WAVELEN_W-2:0]           half_raw;
   logic [sstg_pkg::WAVELEN_W-2:0]           half_len;
   logic [sstg_pkg::CURSOR_W:0]              cursor_next;
   logic [sstg_pkg::CURSOR_W:0]              wrap_len;
   logic                                     out_free;
   logic [sstg_pkg::SAMPLE_W-1:0]            rom_mag;
   logic [sstg_pkg::AMP_W-1:0]               scale_q0;
   logic [sstg_pkg::AMP_W:0]                 scale_rest;
   logic [sstg_pkg::AMP_W-1:0]               scaled;
   logic signed [sstg_pkg::SAMPLE_W-1:0]     amp_pos;

   // Degenerate wavelengths are treated as one frame.
   assign wavelen  = (cfg.samples_per_cycle == '0) ? sstg_pkg::WAVELEN_W'(1)
                                                    : cfg.samples_per_cycle;
   assign half_raw = wavelen[sstg_pkg::WAVELEN_W-1:1];
   assign half_len = (half_raw == '0) ? (sstg_pkg::WAVELEN_W-1)'(1) : half_raw;

   // Cursor advance; a zero wrap means the full cursor range.
   assign cursor_next = {1'b0, cursor_ff} + (sstg_pkg::CURSOR_W+1)'(1);
   assign wrap_len    = (cfg.cursor_wrap == '0) ?
                        {1'b1, {sstg_pkg::CURSOR_W{1'b0}}} : {1'b0, cfg.cursor_wrap};

   assign out_free = !out_valid_ff || pop;
   assign amp_pos  = $signed({1'b0, cfg.amplitude});

   // Magnitude of the table entry, never beyond full scale.
   assign rom_mag = rom_data_ff[sstg_pkg::SAMPLE_W-1] ? 16'(-rom_data_ff) : 16'(rom_data_ff);

   // Division by full scale: x = q0*32768 + lo = q0*32767 + (q0 + lo), and
   // the sum stays below twice the divisor, so one correction suffices.
   assign scale_q0   = product_ff[2*sstg_pkg::AMP_W-1:sstg_pkg::AMP_W];
   assign scale_rest = {1'b0, product_ff[sstg_pkg::AMP_W-1:0]} + {1'b0, scale_q0};
   assign scaled     = scale_q0 + sstg_pkg::AMP_W'(scale_rest >= sstg_pkg::SINE_FULL_SCALE);

   // Frame sequencer.
   always_comb begin
      state_in         = state_ff;
      frames_left_in   = frames_left_ff;
      cursor_in        = cursor_ff;
      product_in       = product_ff;
      negative_in      = negative_ff;
      sample_in        = sample_ff;
      out_load         = 1'b0;
      cmd_pop          = 1'b0;
      div_req          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.valid) begin
               cmd_pop        = 1'b1;
               frames_left_in = cmd.count;
               state_in       = ST_START;
            end
         end
         ST_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, cursor_ff};
            div_req.rem_init = '0;
            div_req.steps    = sstg_pkg::DIV_STEP_W'(sstg_pkg::DIV_DVD_W);
            if (cfg.wave_select == sstg_pkg::WAVE_SQUARE) begin
               div_req.divisor = sstg_pkg::DIV_DSR_W'(half_len);
            end else begin
               div_req.divisor = sstg_pkg::DIV_DSR_W'(wavelen);
            end
            state_in = ST_DIV_MAIN;
         end
         ST_DIV_MAIN: begin
            if (div_rsp.done) begin
               if (cfg.wave_select == sstg_pkg::WAVE_SQUARE) begin
                  sample_in = div_rsp.quotient[0] ? amp_pos : -amp_pos;
                  state_in  = ST_EMIT;
               end else begin
                  // Table index: continue from the phase with zero bits.
                  div_req.start    = 1'b1;
                  div_req.dividend = '0;
                  div_req.divisor  = sstg_pkg::DIV_DSR_W'(wavelen);
                  div_req.rem_init = div_rsp.remainder;
                  div_req.steps    = sstg_pkg::DIV_STEP_W'(sstg_pkg::SINE_IDX_W);
                  state_in         = ST_DIV_IDX;
               end
            end
         end
         ST_DIV_IDX: begin
            if (div_rsp.done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            product_in  = rom_mag[sstg_pkg::AMP_W-1:0] * cfg.amplitude;
            negative_in = rom_data_ff[sstg_pkg::SAMPLE_W-1];
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            sample_in = negative_ff ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load       = 1'b1;
               frames_left_in = frames_left_ff - 1'b1;
               if (cursor_next < wrap_len) begin
                  cursor_in = cursor_next[sstg_pkg::CURSOR_W-1:0];
               end else if (cursor_next == wrap_len) begin
                  cursor_in = '0;
               end
               if (cursor_next > wrap_len) begin
                  // Cursor left above a lowered wrap: fold it back.
                  div_req.start    = 1'b1;
                  div_req.dividend = cursor_next;
                  div_req.divisor  = cfg.cursor_wrap;
                  div_req.rem_init = '0;
                  div_req.steps    = sstg_pkg::DIV_STEP_W'(sstg_pkg::DIV_DVD_W);
                  state_in         = ST_WRAP;
               end else if (frames_left_ff == sstg_pkg::FRAME_COUNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_WRAP: begin
            if (div_rsp.done) begin
               cursor_in = div_rsp.remainder;
               state_in  = (frames_left_ff == '0) ? ST_IDLE : ST_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loaded when free or being taken in the same cycle.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frames_left_ff <= '0;
         cursor_ff      <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frames_left_ff <= frames_left_in;
         cursor_ff      <= cursor_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Datapath registers and the registered sine ROM read.
   always_ff @(posedge clock) begin
      rom_data_ff <= SINE_ROM[div_rsp.quotient[sstg_pkg::SINE_IDX_W-1:0]];
      product_ff  <= product_in;
      negative_ff <= negative_in;
      sample_ff   <= sample_in;
      if (out_load) begin
         out_sample_ff <= sample_ff;
         out_index_ff  <= cursor_ff;
         out_last_ff   <= (frames_left_ff == sstg_pkg::FRAME_COUNT_W'(1));
      end
   end

   assign empty            = !out_valid_ff;
   assign rsp_left_sample  = out_sample_ff;
   assign rsp_right_sample = out_sample_ff;
   assign rsp_frame_index  = out_index_ff;
   assign rsp_last         = out_last_ff;

endmodule

@@ design/square_sine_tone_generator_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Square and sine tone generator
// Each request asks for a run of stereo frames of a square or sine tone; one
// result carries one frame. A front holds the registers and a short request
// queue, a back computes frames through a shared iterative divider.
// ============================================================================
//
// Channel    Ports                                    Handshake
// request    req_frame_count                          push / full
// result     rsp_left_sample, rsp_right_sample,       empty / pop
//            rsp_frame_index, rsp_last
// config     csr_index, csr_wdata                     csr_wr_en, no wait
//
// For a square frame the shared divider works through the cursor; for a sine
// frame it goes on to the table index, followed by the ROM read, the multiply
// and the scaling step. A cursor left above a lowered wrap costs one further
// division on that frame.
// Reset is synchronous and active high; there is no clearing pass.
// A full output register stalls the back; two requests may queue meanwhile.
module square_sine_tone_generator_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   output logic                                    full,
   input  logic [sstg_pkg::FRAME_COUNT_W-1:0]      req_frame_count,
   output logic                                    empty,
   input  logic                                    pop,
   output logic signed [sstg_pkg::SAMPLE_W-1:0]    rsp_left_sample,
   output logic signed [sstg_pkg::SAMPLE_W-1:0]    rsp_right_sample,
   output logic [sstg_pkg::CURSOR_W-1:0]           rsp_frame_index,
   output logic                                    rsp_last,
   input  logic                                    csr_wr_en,
   input  logic [sstg_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [sstg_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   sstg_pkg::cfg_type     cfg;
   sstg_pkg::cmd_type     cmd;
   logic                  cmd_pop;
   sstg_pkg::div_req_type div_req;
   sstg_pkg::div_rsp_type div_rsp;

   // Registers and request queue.
   sstg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_frame_count (req_frame_count),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cfg             (cfg),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   // Shared divider for phase, table index and cursor folding.
   sstg_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Frame sequencer and output register.
   sstg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .empty            (empty),
      .pop              (pop),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_last         (rsp_last)
   );

endmodule
